>>> design/pfm_pkg.sv
// Shared types, constants and helper functions for the polyphonic FM synthesizer.
// Depends on nothing; every other design file imports it.
package pfm_pkg;

    localparam int VOICES         = 16;
    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int TIME_BITS      = 20;
    localparam int OUTPUT_GAIN    = 5000;

    localparam int V_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NOTE_OFS = 89;
    localparam int DUR_W    = 20;
    localparam int LVL_W    = 16;
    localparam int EXT_W    = ((TIME_BITS > DUR_W) ? TIME_BITS : DUR_W) + 1;
    localparam int NUM_W    = EXT_W - 1 + LVL_W;
    localparam int QUOT_W   = 16;
    localparam int NOTE_MAX = VOICES - 1 + NOTE_OFS + 63 + 2;
    localparam int INC_W    = 21 + NOTE_MAX / 12 + 1;
    localparam int MA_W     = (INC_W > 34) ? INC_W : 34;
    localparam int MB_W     = 17;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int ACC_W    = 18 + V_W;

    typedef struct packed {
        logic [PHASE_BITS-1:0] cph;
        logic [PHASE_BITS-1:0] mph;
        logic [TIME_BITS-1:0]  vtime;
        logic [LVL_W-1:0]      held;
    } t_voice;

    typedef struct packed {
        logic           we;
        logic [V_W-1:0] addr;
        t_voice         data;
    } t_ram_wr;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DUR_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

    // Phase increment of the lowest octave, 2^32 units per turn at 44.1 kHz.
    function automatic logic [20:0] base_inc(input logic [3:0] s);
        case (s)
            4'd0:    return 21'd796273;
            4'd1:    return 21'd843622;
            4'd2:    return 21'd893787;
            4'd3:    return 21'd946934;
            4'd4:    return 21'd1003241;
            4'd5:    return 21'd1062897;
            4'd6:    return 21'd1126101;
            4'd7:    return 21'd1193062;
            4'd8:    return 21'd1264005;
            4'd9:    return 21'd1339167;
            4'd10:   return 21'd1418798;
            4'd11:   return 21'd1503164;
            default: return 21'd0;
        endcase
    endfunction

    // Note number (two's complement) to phase increment. The octave is found
    // by multiplying with 171/2048, exact for all notes below 256.
    function automatic logic [INC_W-1:0] note_inc(input logic [10:0] n);
        logic [8:0]  nc;
        logic [17:0] prod;
        logic [4:0]  oct;
        logic [8:0]  semi;
        nc   = n[10] ? 9'd0 : n[8:0];
        prod = 18'(nc) * 18'd171;
        oct  = prod[15:11];
        semi = nc - 9'({oct, 3'b000}) - 9'({oct, 2'b00});
        return INC_W'(base_inc(semi[3:0])) << oct;
    endfunction

    // Quarter-wave folded table position in Q15 for a 32-bit phase.
    function automatic logic [15:0] sine_u(input logic [31:0] ph);
        logic [SINE_ADDR_BITS-1:0] addr;
        logic [SINE_ADDR_BITS-2:0] p;
        addr = ph[31 -: SINE_ADDR_BITS];
        p    = {1'b0, addr[SINE_ADDR_BITS-3:0]};
        if (addr[SINE_ADDR_BITS-2]) begin
            p = {1'b1, {(SINE_ADDR_BITS-2){1'b0}}} - p;
        end
        return 16'(p) << (15 - (SINE_ADDR_BITS - 2));
    endfunction

    function automatic logic [31:0] align_ph(input logic [PHASE_BITS-1:0] p);
        return 32'(p) << (32 - PHASE_BITS);
    endfunction

endpackage

>>> design/poly_fm_synth_adsr_top.sv
// Top level of the 16-voice two-operator FM synthesizer with linear ADSR envelopes.
// Depends on pfm_pkg, pfm_voice_ram and pfm_div.
//
// Usage: each input item carries an opcode and a key. A key press (opcode 1)
// starts the voice of that key with a fresh attack; a key release (opcode 2)
// fades it linearly from its last level. A sample tick (opcode 0) advances
// every active voice by one sample and returns one item: the saturated sum of
// all voices. Press, release and unknown opcodes return nothing.
// Voice state lives in a single-port-read memory. A tick walks the voices in
// turn through a read-modify-write sequencer built around one shared
// multiplier and an iterative divider. An idle voice is skipped; an active
// voice waits on the divider except in the sustain segment; a voice whose
// release has just run out is stored and silenced without the sine steps.
// Only one item is worked on at a time.
// The result sits in an output register, so a new item is accepted while the
// receiver stalls; a later tick waits at its end until that register is free.
// Reset (synchronous, active low) silences all voices and reloads the default
// configuration. Configuration writes must only happen while the block is idle.
module poly_fm_synth_adsr_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_key,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [15:0] o_sample
);
    import pfm_pkg::*;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [2:0] CFG_TRANSPOSE = 3'd0;
    localparam logic [2:0] CFG_BEND      = 3'd1;
    localparam logic [2:0] CFG_DEPTH     = 3'd2;
    localparam logic [2:0] CFG_RATIO     = 3'd3;
    localparam logic [2:0] CFG_ATTACK    = 3'd4;
    localparam logic [2:0] CFG_DECAY     = 3'd5;
    localparam logic [2:0] CFG_SUSTAIN   = 3'd6;
    localparam logic [2:0] CFG_RELEASE   = 3'd7;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_KRD   = 5'd1;
    localparam logic [4:0] S_KWR   = 5'd2;
    localparam logic [4:0] S_VSEL  = 5'd3;
    localparam logic [4:0] S_BEND  = 5'd4;
    localparam logic [4:0] S_INC   = 5'd5;
    localparam logic [4:0] S_INCM  = 5'd6;
    localparam logic [4:0] S_PH    = 5'd7;
    localparam logic [4:0] S_DIVGO = 5'd8;
    localparam logic [4:0] S_DIVW  = 5'd9;
    localparam logic [4:0] S_SA    = 5'd10;
    localparam logic [4:0] S_SB    = 5'd11;
    localparam logic [4:0] S_SC    = 5'd12;
    localparam logic [4:0] S_SD    = 5'd13;
    localparam logic [4:0] S_SE    = 5'd14;
    localparam logic [4:0] S_OFF   = 5'd15;
    localparam logic [4:0] S_OUT1  = 5'd16;
    localparam logic [4:0] S_OUT2  = 5'd17;
    localparam logic [4:0] S_DONE  = 5'd18;

    // Envelope segment chosen for the current voice.
    localparam logic [2:0] M_SUS = 3'd0;
    localparam logic [2:0] M_DEC = 3'd1;
    localparam logic [2:0] M_ATK = 3'd2;
    localparam logic [2:0] M_REL = 3'd3;
    localparam logic [2:0] M_OFF = 3'd4;

    localparam logic [V_W-1:0] LAST_V = V_W'(VOICES - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-32768);

    // Configuration registers.
    logic [6:0]       r_transpose;
    logic [15:0]      r_bend;
    logic [15:0]      r_depth;
    logic [15:0]      r_ratio;
    logic [DUR_W-1:0] r_attack;
    logic [DUR_W-1:0] r_decay;
    logic [15:0]      r_sustain;
    logic [DUR_W-1:0] r_release;

    // Sequencer state and the working registers of the current voice.
    logic [4:0]               r_state,    n_state;
    logic [V_W-1:0]           r_v,        n_v;
    logic [1:0]               r_op,       n_op;
    logic signed [ACC_W-1:0]  r_acc,      n_acc;
    logic [VOICES-1:0]        r_active,   n_active;
    logic [VOICES-1:0]        r_keyheld,  n_keyheld;
    logic [INC_W-1:0]         r_i2,       n_i2;
    logic [INC_W-1:0]         r_diff,     n_diff;
    logic [INC_W-1:0]         r_inc,      n_inc;
    logic [PHASE_BITS-1:0]    r_cph,      n_cph;
    logic [PHASE_BITS-1:0]    r_mph,      n_mph;
    logic [2:0]               r_mode,     n_mode;
    logic [DUR_W-1:0]         r_den,      n_den;
    logic [LVL_W-1:0]         r_lvl,      n_lvl;
    logic [31:0]              r_sph,      n_sph;
    logic                     r_second,   n_second;
    logic [15:0]              r_u,        n_u;
    logic [16:0]              r_u2,       n_u2;
    logic                     r_neg,      n_neg;
    logic                     r_sgn,      n_sgn;
    logic                     r_out_valid, n_out_valid;
    logic [15:0]              r_sample,   n_sample;
    logic [PROD_W-1:0]        r_prod;

    logic [MA_W-1:0]  w_ma;
    logic [MB_W-1:0]  w_mb;
    logic             w_rd_en;
    t_ram_wr          w_wr;
    t_voice           w_rd;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    logic             w_bneg;
    logic [15:0]      w_bmag;
    logic [10:0]      w_note;
    logic [INC_W-1:0] w_i2;
    logic [INC_W-1:0] w_ib;
    logic [INC_W-1:0] w_bshift;
    logic [15:0]      w_sus;
    logic [DUR_W-1:0] w_a1;
    logic [DUR_W-1:0] w_d1;
    logic [DUR_W-1:0] w_r1;
    logic [EXT_W-1:0] w_t;
    logic [EXT_W-1:0] w_a;
    logic [EXT_W-1:0] w_d;
    logic [EXT_W-1:0] w_r;
    logic [15:0]      w_su;
    logic [16:0]      w_pq;
    logic [31:0]      w_off;
    logic signed [ACC_W-1:0] w_term;
    logic             w_key_ok;

    function automatic logic [31:0] w_neg_off(input logic [31:0] x, input logic neg);
        return neg ? (~x + 32'd1) : x;
    endfunction

    pfm_voice_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_v),
        .o_rd_data (w_rd)
    );

    pfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Derived configuration values: zero durations divide by one, sustain is
    // clamped to unity, and bend is handled as sign and magnitude.
    assign w_bneg   = r_bend[15];
    assign w_bmag   = w_bneg ? (~r_bend + 16'd1) : r_bend;
    assign w_sus    = (r_sustain > 16'd32768) ? 16'd32768 : r_sustain;
    assign w_a1     = (r_attack == '0) ? DUR_W'(1) : r_attack;
    assign w_d1     = (r_decay == '0) ? DUR_W'(1) : r_decay;
    assign w_r1     = (r_release == '0) ? DUR_W'(1) : r_release;
    assign w_t      = EXT_W'(w_rd.vtime);
    assign w_a      = EXT_W'(r_attack);
    assign w_d      = EXT_W'(r_decay);
    assign w_r      = EXT_W'(r_release);
    assign w_key_ok = (32'(i_key) < VOICES);

    assign w_note   = 11'(r_v) + 11'(NOTE_OFS) + {{4{r_transpose[6]}}, r_transpose};
    assign w_i2     = note_inc(w_note);
    assign w_ib     = w_bneg ? note_inc(w_note - 11'd2) : note_inc(w_note + 11'd2);
    assign w_bshift = INC_W'(r_prod >> 14);
    assign w_su     = sine_u(r_sph);
    assign w_pq     = 17'(r_prod >> 15);
    assign w_off    = w_neg_off(32'(r_prod) << 1, r_neg);
    assign w_term   = ACC_W'(r_prod >> 30);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    always_comb begin
        n_state     = r_state;
        n_v         = r_v;
        n_op        = r_op;
        n_acc       = r_acc;
        n_active    = r_active;
        n_keyheld   = r_keyheld;
        n_i2        = r_i2;
        n_diff      = r_diff;
        n_inc       = r_inc;
        n_cph       = r_cph;
        n_mph       = r_mph;
        n_mode      = r_mode;
        n_den       = r_den;
        n_lvl       = r_lvl;
        n_sph       = r_sph;
        n_second    = r_second;
        n_u         = r_u;
        n_u2        = r_u2;
        n_neg       = r_neg;
        n_sgn       = r_sgn;
        n_sample    = r_sample;
        n_out_valid = r_out_valid & ~i_out_ready;
        w_ma        = '0;
        w_mb        = '0;
        w_rd_en     = 1'b0;
        w_wr        = '0;
        w_wr.addr   = r_v;
        w_div_req   = '0;
        w_div_req.num = r_prod[NUM_W-1:0];
        w_div_req.den = r_den;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_opcode;
                    n_v  = V_W'(i_key);
                    case (i_opcode)
                        OP_TICK: begin
                            n_v     = '0;
                            n_acc   = '0;
                            n_state = S_VSEL;
                        end
                        OP_PRESS, OP_RELEASE: begin
                            if (w_key_ok) begin
                                n_state = S_KRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_KRD: begin
                w_rd_en = 1'b1;
                n_state = S_KWR;
            end
            S_KWR: begin
                // Presses keep the running phases and restart the envelope.
                w_wr.data = w_rd;
                w_wr.data.vtime = '0;
                if (r_op == OP_PRESS) begin
                    w_wr.we         = 1'b1;
                    w_wr.data.held  = '0;
                    n_keyheld[r_v]  = 1'b1;
                    n_active[r_v]   = 1'b1;
                end else if (r_active[r_v] && r_keyheld[r_v]) begin
                    w_wr.we         = 1'b1;
                    n_keyheld[r_v]  = 1'b0;
                end
                n_state = S_IDLE;
            end
            S_VSEL: begin
                if (!r_active[r_v]) begin
                    if (r_v == LAST_V) begin
                        n_state = S_DONE;
                    end else begin
                        n_v = r_v + 1'b1;
                    end
                end else begin
                    w_rd_en = 1'b1;
                    n_i2    = w_i2;
                    n_diff  = w_bneg ? (w_i2 - w_ib) : (w_ib - w_i2);
                    n_state = S_BEND;
                end
            end
            S_BEND: begin
                w_ma    = MA_W'(r_diff);
                w_mb    = MB_W'(w_bmag);
                n_state = S_INC;
            end
            S_INC: begin
                n_inc   = w_bneg ? (r_i2 - w_bshift) : (r_i2 + w_bshift);
                n_state = S_INCM;
            end
            S_INCM: begin
                w_ma    = MA_W'(r_inc);
                w_mb    = MB_W'(r_ratio);
                n_cph   = w_rd.cph + r_inc[31 -: PHASE_BITS];
                n_state = S_PH;
            end
            S_PH: begin
                // The modulator increment is the product shifted down by eight.
                n_mph = w_rd.mph + r_prod[39 -: PHASE_BITS];
                if (r_keyheld[r_v]) begin
                    if (w_t > w_a + w_d) begin
                        n_mode = M_SUS;
                    end else if (w_t > w_a) begin
                        n_mode = M_DEC;
                        w_ma   = MA_W'(w_t - w_a);
                        w_mb   = 17'd32768 - MB_W'(w_sus);
                        n_den  = w_d1;
                    end else begin
                        n_mode = M_ATK;
                        w_ma   = MA_W'(w_t);
                        w_mb   = 17'd32768;
                        n_den  = w_a1;
                    end
                end else if (w_t > w_r) begin
                    n_mode = M_OFF;
                end else begin
                    n_mode = M_REL;
                    w_ma   = MA_W'(w_r - w_t);
                    w_mb   = MB_W'(w_rd.held);
                    n_den  = w_r1;
                end
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                n_sph    = align_ph(r_mph);
                n_second = 1'b0;
                case (r_mode)
                    M_SUS: begin
                        n_lvl   = w_sus;
                        n_state = S_SA;
                    end
                    M_OFF: begin
                        // The release has run out: store the advanced phases
                        // and silence the voice without a sample term.
                        w_wr.we         = 1'b1;
                        w_wr.data.cph   = r_cph;
                        w_wr.data.mph   = r_mph;
                        w_wr.data.vtime = w_rd.vtime;
                        w_wr.data.held  = '0;
                        n_active[r_v]   = 1'b0;
                        if (r_v == LAST_V) begin
                            n_state = S_DONE;
                        end else begin
                            n_v     = r_v + 1'b1;
                            n_state = S_VSEL;
                        end
                    end
                    default: begin
                        w_div_req.start = 1'b1;
                        n_state         = S_DIVW;
                    end
                endcase
            end
            S_DIVW: begin
                if (w_div_rsp.done) begin
                    if (r_mode == M_DEC) begin
                        n_lvl = LVL_W'(17'd32768 - 17'(w_div_rsp.quot));
                    end else begin
                        n_lvl = w_div_rsp.quot;
                    end
                    n_state = S_SA;
                end
            end
            S_SA: begin
                n_u     = w_su;
                n_neg   = r_sph[31];
                w_ma    = MA_W'(w_su);
                w_mb    = MB_W'(w_su);
                n_state = S_SB;
            end
            S_SB: begin
                n_u2    = w_pq;
                w_ma    = MA_W'(w_pq);
                w_mb    = 17'd2463;
                n_state = S_SC;
            end
            S_SC: begin
                w_ma    = MA_W'(r_u2);
                w_mb    = 17'd21167 - w_pq;
                n_state = S_SD;
            end
            S_SD: begin
                w_ma    = MA_W'(r_u);
                w_mb    = 17'd51472 - w_pq;
                n_state = S_SE;
            end
            S_SE: begin
                w_mb = w_pq;
                if (!r_second) begin
                    w_ma    = MA_W'(r_depth);
                    n_state = S_OFF;
                end else begin
                    w_ma    = MA_W'(r_lvl);
                    n_sgn   = r_neg;
                    n_state = S_OUT1;
                end
            end
            S_OFF: begin
                n_sph    = align_ph(r_cph) + w_off;
                n_second = 1'b1;
                n_state  = S_SA;
            end
            S_OUT1: begin
                w_ma    = MA_W'(r_prod);
                w_mb    = MB_W'(OUTPUT_GAIN);
                n_state = S_OUT2;
            end
            S_OUT2: begin
                n_acc           = r_sgn ? (r_acc - w_term) : (r_acc + w_term);
                w_wr.we         = 1'b1;
                w_wr.data.cph   = r_cph;
                w_wr.data.mph   = r_mph;
                w_wr.data.vtime = (w_rd.vtime == '1) ? w_rd.vtime : (w_rd.vtime + 1'b1);
                w_wr.data.held  = r_keyheld[r_v] ? r_lvl : w_rd.held;
                if (r_v == LAST_V) begin
                    n_state = S_DONE;
                end else begin
                    n_v     = r_v + 1'b1;
                    n_state = S_VSEL;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_acc > SAT_HI) begin
                        n_sample = 16'h7FFF;
                    end else if (r_acc < SAT_LO) begin
                        n_sample = 16'h8000;
                    end else begin
                        n_sample = r_acc[15:0];
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_keyheld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_keyheld   <= n_keyheld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v      <= n_v;
        r_op     <= n_op;
        r_acc    <= n_acc;
        r_i2     <= n_i2;
        r_diff   <= n_diff;
        r_inc    <= n_inc;
        r_cph    <= n_cph;
        r_mph    <= n_mph;
        r_mode   <= n_mode;
        r_den    <= n_den;
        r_lvl    <= n_lvl;
        r_sph    <= n_sph;
        r_second <= n_second;
        r_u      <= n_u;
        r_u2     <= n_u2;
        r_neg    <= n_neg;
        r_sgn    <= n_sgn;
        r_sample <= n_sample;
        r_prod   <= PROD_W'(w_ma) * PROD_W'(w_mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transpose <= 7'd24;
            r_bend      <= 16'd0;
            r_depth     <= 16'd7300;
            r_ratio     <= 16'd85;
            r_attack    <= DUR_W'(2205);
            r_decay     <= DUR_W'(13230);
            r_sustain   <= 16'd26214;
            r_release   <= DUR_W'(8820);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRANSPOSE: r_transpose <= i_cfg_data[6:0];
                CFG_BEND:      r_bend      <= i_cfg_data[15:0];
                CFG_DEPTH:     r_depth     <= i_cfg_data[15:0];
                CFG_RATIO:     r_ratio     <= i_cfg_data[15:0];
                CFG_ATTACK:    r_attack    <= i_cfg_data;
                CFG_DECAY:     r_decay     <= i_cfg_data;
                CFG_SUSTAIN:   r_sustain   <= i_cfg_data[15:0];
                CFG_RELEASE:   r_release   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A voice can only hold its key while it is sounding.
    a_held_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_keyheld & ~r_active) == '0)
        else $error("key held on an inactive voice");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIVW))
        else $error("divider result arrived outside its wait state");

    // A finished tick always lands in the output register and frees the input.
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || i_out_ready))
        |=> (o_out_valid && o_in_ready))
        else $error("tick result not presented");
`endif

endmodule

>>> design/pfm_voice_ram.sv
// Voice state memory: phases, envelope time and held level for every voice.
// Depends on pfm_pkg. Entries never written read as zero.
module pfm_voice_ram (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pfm_pkg::t_ram_wr        i_wr,
    input  logic                    i_rd_en,
    input  logic [pfm_pkg::V_W-1:0] i_rd_addr,
    output pfm_pkg::t_voice         o_rd_data
);
    import pfm_pkg::*;

    t_voice              r_mem [VOICES];
    logic [VOICES-1:0]   r_wvalid;
    t_voice              r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
        end else if (i_wr.we) begin
            r_wvalid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata <= r_wvalid[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rdata;

endmodule

>>> design/pfm_div.sv
// Restoring divider for the envelope, one quotient bit per cycle.
// Depends on pfm_pkg. The quotient must fit in QUOT_W bits.
module pfm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfm_pkg::t_div_req i_req,
    output pfm_pkg::t_div_rsp o_rsp
);
    import pfm_pkg::*;

    localparam int DSH_W = DUR_W + QUOT_W - 1;
    localparam int CNT_W = $clog2(QUOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [QUOT_W-1:0] r_q;
    logic              w_ge;

    assign w_ge = (r_rem >= NUM_W'(r_dsh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_dsh <= DSH_W'(i_req.den) << (QUOT_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - NUM_W'(r_dsh);
            end
            r_q   <= {r_q[QUOT_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for poly_fm_synth_adsr_top: predicts every mixed sample
// of the 16-voice FM synthesizer and compares it with the block's output items.
// Depends on pfm_pkg and the design files of the synthesizer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfm_pkg::*;

    // Opcodes and register indexes, written by name throughout.
    typedef enum logic [1:0] {OP_TICK = 2'd0, OP_PRESS = 2'd1, OP_RELEASE = 2'd2,
                              OP_UNUSED = 2'd3} op_e;
    typedef enum logic [2:0] {R_TRANSPOSE = 3'd0, R_BEND = 3'd1, R_DEPTH = 3'd2,
                              R_RATIO = 3'd3, R_ATTACK = 3'd4, R_DECAY = 3'd5,
                              R_SUSTAIN = 3'd6, R_RELEASE = 3'd7} reg_e;

    localparam longint CYCLE_LIMIT = 4_000_000;
    localparam int     NV = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_opcode = '0;
    logic [3:0]  i_key = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic signed [15:0] o_sample;

    poly_fm_synth_adsr_top dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Predictor copy of the configuration registers.
    logic [6:0]  cur_transpose;
    logic [15:0] cur_bend, cur_depth, cur_ratio, cur_sustain;
    logic [19:0] cur_attack, cur_decay, cur_release;

    // Predictor copy of the voice state.
    logic [31:0] car_ph [NV];
    logic [31:0] mod_ph [NV];
    logic [19:0] v_time [NV];
    logic [15:0] v_held [NV];
    bit          v_gate [NV];
    bit          v_on   [NV];

    logic signed [15:0] sample_fifo[$];
    int  n_errors = 0;
    longint cycles = 0;

    function automatic longint unsigned inc_of_note(input int n);
        longint unsigned semis [12] = '{796273, 843622, 893787, 946934, 1003241, 1062897,
                                        1126101, 1193062, 1264005, 1339167, 1418798,
                                        1503164};
        if (n < 0) n = 0;
        return semis[n % 12] << (n / 12);
    endfunction

    function automatic longint unsigned voice_step(input int v);
        int tr;
        int bend;
        int n;
        longint unsigned mid;
        tr = $signed(cur_transpose);
        bend = $signed(cur_bend);
        n = v + 89 + tr;
        mid = inc_of_note(n);
        if (bend > 0)
            return mid + (((inc_of_note(n + 2) - mid) * longint'(bend)) >> 14);
        if (bend < 0)
            return mid - (((mid - inc_of_note(n - 2)) * longint'(-bend)) >> 14);
        return mid;
    endfunction

    // Quarter-wave polynomial sine, Q15 in [-32768, 32768].
    function automatic int sine_of(input logic [31:0] ph);
        int unsigned addr, quad, p;
        longint unsigned u, u2, t;
        addr = ph >> 22;
        quad = (addr >> 8) & 3;
        p = addr & 255;
        if (quad[0]) p = 256 - p;
        u = longint'(p) << 7;
        u2 = (u * u) >> 15;
        t = 21167 - ((u2 * 2463) >> 15);
        t = 51472 - ((u2 * t) >> 15);
        t = (u * t) >> 15;
        return quad[1] ? -int'(t) : int'(t);
    endfunction

    // Envelope level in Q1.15; ends the voice when its release has run out.
    function automatic longint unsigned adsr_level(input int v);
        longint unsigned t, a, d, r, s, lvl;
        t = v_time[v];
        a = (cur_attack != 0) ? cur_attack : 1;
        d = (cur_decay != 0) ? cur_decay : 1;
        r = (cur_release != 0) ? cur_release : 1;
        s = (cur_sustain > 16'd32768) ? 32768 : cur_sustain;
        if (v_gate[v]) begin
            if (t > longint'(cur_attack) + cur_decay) lvl = s;
            else if (t > cur_attack) lvl = 32768 - ((32768 - s) * (t - cur_attack)) / d;
            else lvl = (t * 32768) / a;
            v_held[v] = lvl[15:0];
            return lvl;
        end
        if (t > cur_release) begin
            v_on[v] = 0;
            v_held[v] = '0;
            return 0;
        end
        return (longint'(v_held[v]) * (cur_release - t)) / r;
    endfunction

    // Advances every active voice by one sample and returns the saturated mix.
    function automatic logic signed [15:0] mix_next_sample();
        longint acc;
        longint unsigned inc, incm, lvl, mag;
        longint prod;
        int sm, sc;
        logic [31:0] off, arg;
        acc = 0;
        for (int v = 0; v < NV; v++) begin
            if (!v_on[v]) continue;
            inc = voice_step(v);
            incm = (inc * cur_ratio) >> 8;
            car_ph[v] = car_ph[v] + inc[31:0];
            mod_ph[v] = mod_ph[v] + incm[31:0];
            lvl = adsr_level(v);
            if (!v_on[v]) continue;
            sm = sine_of(mod_ph[v]);
            off = 32'(longint'(cur_depth) * sm * 2);
            arg = car_ph[v] + off;
            sc = sine_of(arg);
            prod = longint'(OUTPUT_GAIN) * longint'(lvl) * sc;
            mag = (prod < 0) ? -prod : prod;
            acc += (prod < 0) ? -longint'(mag >> 30) : longint'(mag >> 30);
            if (v_time[v] != 20'hFFFFF) v_time[v]++;
        end
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        return acc[15:0];
    endfunction

    function automatic void predictor_reset();
        cur_transpose = 7'd24; cur_bend = 16'd0; cur_depth = 16'd7300;
        cur_ratio = 16'd85; cur_attack = 20'd2205; cur_decay = 20'd13230;
        cur_sustain = 16'd26214; cur_release = 20'd8820;
        for (int v = 0; v < NV; v++) begin
            car_ph[v] = '0; mod_ph[v] = '0; v_time[v] = '0; v_held[v] = '0;
            v_gate[v] = 0; v_on[v] = 0;
        end
    endfunction

    // Applies one accepted item to the predictor.
    function automatic void predict_item(input op_e op, input logic [3:0] key);
        case (op)
            OP_PRESS: begin
                v_time[key] = '0; v_held[key] = '0; v_gate[key] = 1; v_on[key] = 1;
            end
            OP_RELEASE: begin
                if (v_on[key] && v_gate[key]) begin
                    v_gate[key] = 0; v_time[key] = '0;
                end
            end
            OP_TICK: begin
                sample_fifo.push_back(mix_next_sample());
            end
            default: ;
        endcase
    endfunction

    // Random gap: mostly none or short, occasionally long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    bit sender_idle_ok = 1;

    // Valid stays high after an item is accepted so that the next call can
    // follow back to back; a gap or any waiting task drops it first.
    task automatic send_item(input op_e op, input logic [3:0] key);
        int gap;
        gap = sender_idle_ok ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_key <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(op, key);
    endtask

    // Stops sending and waits until the block is idle with no result pending.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sample_fifo.size() != 0 || !o_in_ready) @(posedge i_clk);
    endtask

    // Waits until every predicted sample has come back, then lets the block settle.
    task automatic wait_quiet();
        wait_idle();
        repeat (700) @(posedge i_clk);
    endtask

    task automatic write_reg(input reg_e idx, input logic [19:0] val);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            R_TRANSPOSE: cur_transpose = val[6:0];
            R_BEND:      cur_bend = val[15:0];
            R_DEPTH:     cur_depth = val[15:0];
            R_RATIO:     cur_ratio = val[15:0];
            R_ATTACK:    cur_attack = val;
            R_DECAY:     cur_decay = val;
            R_SUSTAIN:   cur_sustain = val[15:0];
            R_RELEASE:   cur_release = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Output side: random stalls, and every accepted item checked against the queue.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sample_fifo.size() == 0) begin
                $error("sample: unexpected item, actual %0d", o_sample);
                n_errors++;
            end else begin
                logic signed [15:0] want;
                want = sample_fifo.pop_front();
                if (want !== o_sample) begin
                    $error("sample: expected %0d actual %0d", want, o_sample);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL poly_fm_synth_adsr_top");
            $finish;
        end
    end

    // Short envelopes so attack, decay, sustain and release all show up quickly.
    task automatic test_directed_envelope();
        write_reg(R_ATTACK, 20'd3);
        write_reg(R_DECAY, 20'd4);
        write_reg(R_SUSTAIN, 16'd20000);
        write_reg(R_RELEASE, 20'd5);
        send_item(OP_PRESS, 4'd0);
        send_item(OP_PRESS, 4'd15);
        repeat (9) send_item(OP_TICK, 4'd0);
        send_item(OP_RELEASE, 4'd0);
        send_item(OP_RELEASE, 4'd0);   // second release of the same voice is ignored
        send_item(OP_RELEASE, 4'd7);   // release of an idle voice is ignored
        send_item(OP_UNUSED, 4'd9);    // unknown opcode gives nothing back
        repeat (8) send_item(OP_TICK, 4'd15);
        send_item(OP_PRESS, 4'd15);    // retrigger restarts the attack
        send_item(OP_TICK, 4'd0);
        wait_quiet();
    endtask

    // Zero durations count as one, sustain above unity is clamped, extreme pitch.
    task automatic test_config_extremes();
        write_reg(R_ATTACK, 20'd0);
        write_reg(R_DECAY, 20'd0);
        write_reg(R_RELEASE, 20'd0);
        write_reg(R_SUSTAIN, 16'hFFFF);
        write_reg(R_TRANSPOSE, 7'h3F);
        write_reg(R_BEND, 16'h4000);
        write_reg(R_DEPTH, 16'hFFFF);
        write_reg(R_RATIO, 16'hFFFF);
        for (int k = 0; k < NV; k++) send_item(OP_PRESS, 4'(k));
        repeat (4) send_item(OP_TICK, 4'd0);
        write_reg(R_TRANSPOSE, 7'h40);
        write_reg(R_BEND, 16'hC000);
        write_reg(R_RATIO, 16'd0);
        write_reg(R_DEPTH, 16'd0);
        repeat (3) send_item(OP_TICK, 4'd0);
        for (int k = 0; k < NV; k++) send_item(OP_RELEASE, 4'(k));
        repeat (3) send_item(OP_TICK, 4'd0);
        wait_quiet();
        write_reg(R_BEND, 16'h8000);   // bend beyond minus one extrapolates
        write_reg(R_ATTACK, 20'hFFFFF);
        write_reg(R_DECAY, 20'hFFFFF);
        write_reg(R_RELEASE, 20'hFFFFF);
        write_reg(R_SUSTAIN, 16'd0);
        send_item(OP_PRESS, 4'd5);
        repeat (3) send_item(OP_TICK, 4'd0);
        wait_quiet();
    endtask

    // Random phrases of presses, ticks and releases under several settings.
    task automatic test_random_phrases();
        int r;
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(R_TRANSPOSE, 20'($urandom_range(0, 127)));
            write_reg(R_BEND, 20'($urandom_range(0, 65535)));
            write_reg(R_DEPTH, 20'($urandom_range(0, 65535)));
            write_reg(R_RATIO, 20'($urandom_range(0, 65535)));
            write_reg(R_ATTACK, 20'($urandom_range(0, 40)));
            write_reg(R_DECAY, 20'($urandom_range(0, 40)));
            write_reg(R_SUSTAIN, 20'($urandom_range(0, 65535)));
            write_reg(R_RELEASE, 20'($urandom_range(0, 40)));
            for (int i = 0; i < 150; i++) begin
                r = $urandom_range(0, 99);
                if (r < 60) send_item(OP_TICK, 4'($urandom_range(0, 15)));
                else if (r < 78) send_item(OP_PRESS, 4'($urandom_range(0, 15)));
                else if (r < 96) send_item(OP_RELEASE, 4'($urandom_range(0, 15)));
                else send_item(OP_UNUSED, 4'($urandom_range(0, 15)));
            end
            // Hold the sender until the block has drained once per phase.
            sender_idle_ok = (phase % 2 == 0);
            wait_quiet();
        end
        sender_idle_ok = 1;
        write_reg(R_TRANSPOSE, 7'd24);
        write_reg(R_BEND, 16'd0);
    endtask

    initial begin
        predictor_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_envelope();
        test_config_extremes();
        test_random_phrases();
        wait_quiet();
        if (n_errors == 0 && sample_fifo.size() == 0) begin
            $display("PASS poly_fm_synth_adsr_top");
        end else begin
            $display("FAIL poly_fm_synth_adsr_top");
        end
        $finish;
    end
endmodule

>>> files.f
design/pfm_pkg.sv
design/pfm_voice_ram.sv
design/pfm_div.sv
design/poly_fm_synth_adsr_top.sv
verif/tb_top.sv
